// ===== rtl/core/dtpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpb_pkg
// Shared types and constants of the drop-tail packet buffer: item structs,
// queue cell contents, chain control and controller states.
// ----------------------------------------------------------------------------
package dtpb_pkg;

   localparam logic       CMD_ARRIVAL = 1'b0;
   localparam logic       CMD_FLUSH   = 1'b1;
   localparam logic [4:0] LIMIT_RESET = 5'd16;
   localparam logic [31:0] CLOCK_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        command;
      logic [15:0] packet_tag;
      logic [31:0] arrival_time;
      logic [15:0] service_time;
   } req_item_type;

   typedef struct packed {
      logic [15:0] result_tag;
      logic [31:0] start_time;
      logic        dropped;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [15:0] duration;
   } cell_data_type;

   typedef struct packed {
      logic shift;
      logic load;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

// ===== rtl/core/drop_tail_packet_buffer_sim.sv =====
// ----------------------------------------------------------------------------
// drop_tail_packet_buffer_sim
// Drop-tail packet buffer in front of a single server. Retires finished
// packets oldest first, then takes in or drops the arriving packet; a flush retires all.
//
//   channel  direction  payload        handshake
//   req      in         req_item_type  req_valid / req_stall
//   rsp      out        rsp_item_type  rsp_valid / rsp_stall
//   csr      in         buffer limit   csr_wr_en, no wait
//
// The controller takes an item, retires finished packets one per cycle while
// rsp is not stalled, then takes in or drops the packet, and drains the last
// result when the item gives any result.
// Reset is synchronous; the queue starts empty and the limit at 16.
// A stalled rsp holds the controller; req is taken only between items.
// ----------------------------------------------------------------------------
module drop_tail_packet_buffer_sim import dtpb_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LIM_W = (OCC_W > 5) ? OCC_W : 5;

   state_type        state_ff,      state_in;
   logic             cmd_ff,        cmd_in;
   logic [15:0]      tag_ff,        tag_in;
   logic [31:0]      arrival_ff,    arrival_in;
   logic [15:0]      dur_ff,        dur_in;
   logic [31:0]      clock_ff,      clock_in;
   logic [OCC_W-1:0] occ_ff,        occ_in;
   logic [4:0]       limit_ff,      limit_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_item_type     pend_ff,       pend_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   rsp_item_type     rsp_ff,        rsp_in;

   chain_ctrl_type chain_ctrl;
   cell_data_type  head_data;
   cell_data_type  load_data;
   logic [32:0]    finish_sum;
   logic [31:0]    finish_sat;
   logic [LIM_W-1:0] limit_eff;
   logic           retire_ok;
   logic           room_ok;
   logic           out_free;

   dtpb_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .OCC_W       (OCC_W)
   ) u_chain (
      .clock      (clock),
      .ctrl       (chain_ctrl),
      .load_index (occ_ff),
      .load_data  (load_data),
      .head_data  (head_data)
   );

   assign load_data.tag      = tag_ff;
   assign load_data.duration = dur_ff;

   assign finish_sum = {1'b0, clock_ff} + {17'b0, head_data.duration};
   assign finish_sat = finish_sum[32] ? CLOCK_MAX : finish_sum[31:0];
   assign limit_eff  = (LIM_W'(limit_ff) > LIM_W'(QUEUE_DEPTH)) ?
                       LIM_W'(QUEUE_DEPTH) : LIM_W'(limit_ff);
   assign retire_ok  = (occ_ff != '0) &&
                       ((cmd_ff == CMD_FLUSH) || (finish_sum <= {1'b0, arrival_ff}));
   assign room_ok    = (occ_ff == '0) || (LIM_W'(occ_ff) < limit_eff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      tag_in        = tag_ff;
      arrival_in    = arrival_ff;
      dur_in        = dur_ff;
      clock_in      = clock_ff;
      occ_in        = occ_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      chain_ctrl    = '0;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      req_stall     = (state_ff != ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_item.command;
               tag_in     = req_item.packet_tag;
               arrival_in = req_item.arrival_time;
               dur_in     = req_item.service_time;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               if (retire_ok) begin
                  chain_ctrl.shift = 1'b1;
                  occ_in           = occ_ff - OCC_W'(1);
                  clock_in         = finish_sat;
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in.result_tag  = head_data.tag;
                  pend_in.start_time  = clock_ff;
                  pend_in.dropped     = 1'b0;
                  pend_in.last_of_run = 1'b0;
                  pend_valid_in       = 1'b1;
               end else if (cmd_ff == CMD_FLUSH) begin
                  state_in = pend_valid_ff ? ST_DRAIN : ST_IDLE;
               end else if (room_ok) begin
                  chain_ctrl.load = 1'b1;
                  occ_in          = occ_ff + OCC_W'(1);
                  if (occ_ff == '0) begin
                     clock_in = arrival_ff;
                  end
                  state_in = pend_valid_ff ? ST_DRAIN : ST_IDLE;
               end else begin
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in.result_tag  = tag_ff;
                  pend_in.start_time  = '0;
                  pend_in.dropped     = 1'b1;
                  pend_in.last_of_run = 1'b0;
                  pend_valid_in       = 1'b1;
                  state_in            = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_in             = pend_ff;
               rsp_in.last_of_run = 1'b1;
               rsp_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clock_ff      <= '0;
         occ_ff        <= '0;
         limit_ff      <= LIMIT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clock_ff      <= clock_in;
         occ_ff        <= occ_in;
         limit_ff      <= limit_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      tag_ff     <= tag_in;
      arrival_ff <= arrival_in;
      dur_ff     <= dur_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      LIM_W'(occ_ff) <= LIM_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_RUN))
      else $error("accepted item did not start a run");

   a_drain_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> pend_valid_ff)
      else $error("drain without a pending result");

   a_retire_count: assert property (@(posedge clock) disable iff (reset)
      chain_ctrl.shift |=> (occ_ff + OCC_W'(1) == $past(occ_ff)))
      else $error("retire did not lower occupancy");

   a_no_shift_load: assert property (@(posedge clock) disable iff (reset)
      !(chain_ctrl.shift && chain_ctrl.load))
      else $error("shift and load in one cycle");
`endif

endmodule

// ===== rtl/core/dtpb_cell.sv =====
// ----------------------------------------------------------------------------
// dtpb_cell
// One queue slot: takes its neighbor's entry on a shift, or a new packet on
// a load.
// ----------------------------------------------------------------------------
module dtpb_cell import dtpb_pkg::*; (
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   input  cell_data_type  load_data,
   input  cell_data_type  next_data,
   output cell_data_type  data_out
);

   cell_data_type data_ff;
   cell_data_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (ctrl.load) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== rtl/core/dtpb_chain.sv =====
// ----------------------------------------------------------------------------
// dtpb_chain
// Row of queue cells with the oldest packet in cell zero. A retire shifts
// every cell toward the head; a new packet loads into the first free cell.
// ----------------------------------------------------------------------------
module dtpb_chain import dtpb_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int OCC_W       = 5
) (
   input  logic             clock,
   input  chain_ctrl_type   ctrl,
   input  logic [OCC_W-1:0] load_index,
   input  cell_data_type    load_data,
   output cell_data_type    head_data
);

   cell_data_type cell_data [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      chain_ctrl_type cell_ctrl;
      cell_data_type  next_data;

      assign cell_ctrl.shift = ctrl.shift;
      assign cell_ctrl.load  = ctrl.load && (load_index == OCC_W'(i));

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      dtpb_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .load_data (load_data),
         .next_data (next_data),
         .data_out  (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

// ===== test/tb_drop_tail_packet_buffer_sim.sv =====
// ----------------------------------------------------------------------------
// tb_drop_tail_packet_buffer_sim
// Self-checking bench for the drop-tail packet buffer. A short directed table
// covers field extremes, flush, the limit of zero, saturation of the service
// clock and decreasing arrivals. Random traffic then follows under several
// buffer limits. A behavioral copy of the queue predicts every retirement and
// drop, and each result item is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_drop_tail_packet_buffer_sim;
   import dtpb_pkg::*;

   localparam int DEPTH       = 16;
   localparam int UNCHECKED   = -1;
   localparam int CYCLE_LIMIT = 800_000;
   localparam int PHASE_ITEMS = 56;
   localparam logic [39:0] PHASE_LIMITS =
      {5'd16, 5'd12, 5'd8, 5'd1, 5'd31, 5'd0, 5'd3, 5'd16};

   typedef enum logic {ROW_PACKET, ROW_LIMIT} row_kind_type;
   typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BLOCKS} flow_type;

   typedef struct {
      row_kind_type kind;
      req_item_type pkt;
      logic [4:0]   limit;
      int           known_cnt;
      rsp_item_type known;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en;
   logic [4:0]   csr_wr_data;

   logic [15:0]  held_tags[$];
   logic [15:0]  held_durs[$];
   logic [31:0]  server_clock;
   logic [4:0]   limit_setting;
   rsp_item_type service_reports[$];
   plan_row_type plan[$];

   int          mismatches = 0;
   int          burst_left = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_tick = 0;
   flow_type    flow_mode = FLOW_FREE;

   drop_tail_packet_buffer_sim #(
      .QUEUE_DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick[5:0] == 6'd0) begin
         flow_mode <= flow_type'($urandom_range(0, 3));
      end
      case (flow_mode)
         FLOW_FREE:   rsp_stall <= 1'b0;
         FLOW_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
         FLOW_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_tick[3:0] < 4'd12);
      endcase
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t %s: expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (service_reports.size() == 0) begin
            mismatches++;
            $display("%0t unexpected item: expected none, got tag %h start %h drop %b last %b",
                     $time, rsp_item.result_tag, rsp_item.start_time,
                     rsp_item.dropped, rsp_item.last_of_run);
         end else begin
            want = service_reports.pop_front();
            check_field("result_tag", 32'(want.result_tag), 32'(rsp_item.result_tag));
            check_field("start_time", want.start_time, rsp_item.start_time);
            check_field("dropped", 32'(want.dropped), 32'(rsp_item.dropped));
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_item.last_of_run));
         end
      end
   end

   function automatic void retire_oldest();
      rsp_item_type rep;
      logic [32:0]  sum;
      rep.result_tag  = held_tags.pop_front();
      rep.start_time  = server_clock;
      rep.dropped     = 1'b0;
      rep.last_of_run = 1'b0;
      sum = {1'b0, server_clock} + {17'd0, held_durs.pop_front()};
      server_clock = sum[32] ? CLOCK_MAX : sum[31:0];
      service_reports.push_back(rep);
   endfunction

   function automatic int predict_service(input req_item_type pkt);
      int           count;
      int unsigned  lim;
      rsp_item_type rep;
      count = service_reports.size();
      lim = (limit_setting > DEPTH) ? DEPTH : limit_setting;
      if (pkt.command == CMD_FLUSH) begin
         while (held_tags.size() != 0) retire_oldest();
      end else begin
         while (held_tags.size() != 0 &&
                {1'b0, server_clock} + {17'd0, held_durs[0]} <= {1'b0, pkt.arrival_time}) begin
            retire_oldest();
         end
         if (held_tags.size() == 0 || held_tags.size() < lim) begin
            if (held_tags.size() == 0) server_clock = pkt.arrival_time;
            held_tags.push_back(pkt.packet_tag);
            held_durs.push_back(pkt.service_time);
         end else begin
            rep.result_tag  = pkt.packet_tag;
            rep.start_time  = '0;
            rep.dropped     = 1'b1;
            rep.last_of_run = 1'b0;
            service_reports.push_back(rep);
         end
      end
      count = service_reports.size() - count;
      if (count > 0) begin
         rep = service_reports.pop_back();
         rep.last_of_run = 1'b1;
         service_reports.push_back(rep);
      end
      return count;
   endfunction

   function automatic rsp_item_type sole_report(input logic [15:0] tag,
                                                input logic [31:0] start, input logic drop);
      rsp_item_type rep;
      rep.result_tag  = tag;
      rep.start_time  = start;
      rep.dropped     = drop;
      rep.last_of_run = 1'b1;
      return rep;
   endfunction

   function automatic plan_row_type packet_row(input logic cmd, input logic [15:0] tag,
                                               input logic [31:0] arrival,
                                               input logic [15:0] dur, input int known_cnt,
                                               input rsp_item_type known);
      plan_row_type row;
      row.kind                 = ROW_PACKET;
      row.pkt.command          = cmd;
      row.pkt.packet_tag       = tag;
      row.pkt.arrival_time     = arrival;
      row.pkt.service_time     = dur;
      row.limit                = '0;
      row.known_cnt            = known_cnt;
      row.known                = known;
      return row;
   endfunction

   function automatic plan_row_type limit_row(input logic [4:0] value);
      plan_row_type row;
      row.kind      = ROW_LIMIT;
      row.pkt       = '0;
      row.limit     = value;
      row.known_cnt = UNCHECKED;
      row.known     = '0;
      return row;
   endfunction

   task automatic offer_item(input req_item_type pkt);
      req_valid <= 1'b1;
      req_item  <= pkt;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (service_reports.size() != 0);
   endtask

   task automatic set_limit(input logic [4:0] value);
      wait_drained();
      repeat (DEPTH + 8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_setting = value;
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      if ($urandom_range(0, 49) == 0) wait_drained();
   endtask

   initial begin : stimulus
      req_item_type pkt;
      logic [31:0]  now;
      logic [32:0]  later;
      logic [4:0]   phase_limit;
      int unsigned  pick;
      int           got;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_item    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      server_clock  = '0;
      limit_setting = LIMIT_RESET;
      now = '0;

      plan.push_back(packet_row(CMD_ARRIVAL, 16'h0000, 32'h0000_0000, 16'h0000, 0, '0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'hFFFF, 32'h0000_0000, 16'hFFFF, 1,
                                sole_report(16'h0000, 32'h0, 1'b0)));
      plan.push_back(packet_row(CMD_FLUSH, 16'h0000, 32'h0000_0000, 16'h0000, 1,
                                sole_report(16'hFFFF, 32'h0, 1'b0)));
      plan.push_back(packet_row(CMD_FLUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, '0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h1234, 32'hFFFF_FFF0, 16'h0100, 0, '0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h5678, 32'hFFFF_FFFF, 16'hFFFF, 0, '0));
      plan.push_back(packet_row(CMD_FLUSH, 16'h0000, 32'h0000_0000, 16'h0000, UNCHECKED, '0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h00AA, 32'h0000_0010, 16'h0005, 0, '0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h00BB, 32'h0000_0010, 16'h0003, 0, '0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h00CC, 32'h0000_0018, 16'h0007, UNCHECKED, '0));
      plan.push_back(limit_row(5'd1));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h0101, 32'h0000_0020, 16'h0010, 1,
                                sole_report(16'h00CC, 32'h18, 1'b0)));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h0202, 32'h0000_0021, 16'h0001, 1,
                                sole_report(16'h0202, 32'h0, 1'b1)));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h0303, 32'h0000_0030, 16'h0002, 1,
                                sole_report(16'h0101, 32'h20, 1'b0)));
      plan.push_back(limit_row(5'd0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h0404, 32'h0000_0030, 16'h0000, 1,
                                sole_report(16'h0404, 32'h0, 1'b1)));
      plan.push_back(packet_row(CMD_FLUSH, 16'h0000, 32'h0000_0000, 16'h0000, 1,
                                sole_report(16'h0303, 32'h30, 1'b0)));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h0505, 32'h0000_0040, 16'h0000, 0, '0));
      plan.push_back(packet_row(CMD_ARRIVAL, 16'h0606, 32'h0000_0040, 16'h0000, 1,
                                sole_report(16'h0505, 32'h40, 1'b0)));
      plan.push_back(limit_row(5'd31));
      plan.push_back(packet_row(CMD_FLUSH, 16'h0000, 32'h0000_0000, 16'h0000, 1,
                                sole_report(16'h0606, 32'h40, 1'b0)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_LIMIT) begin
            set_limit(plan[r].limit);
         end else begin
            pace_sender();
            offer_item(plan[r].pkt);
            got = predict_service(plan[r].pkt);
            if (plan[r].known_cnt != UNCHECKED &&
                (got != plan[r].known_cnt ||
                 (got == 1 && service_reports[$] !== plan[r].known))) begin
               mismatches++;
               $display("%0t row %0d: expected %0d item(s) %p, got %0d item(s)",
                        $time, r, plan[r].known_cnt, plan[r].known, got);
            end
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         phase_limit = PHASE_LIMITS[phase*5 +: 5];
         if (phase == 6) phase_limit = 5'($urandom_range(2, 15));
         set_limit(phase_limit);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pace_sender();
            pick = $urandom_range(0, 99);
            pkt.packet_tag = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: pkt.service_time = 16'($urandom_range(0, 40));
               7, 8:                pkt.service_time = 16'($urandom_range(0, 400));
               default:             pkt.service_time = 16'($urandom_range(0, 65535));
            endcase
            if (pick < 6) begin
               pkt.command      = CMD_FLUSH;
               pkt.arrival_time = $urandom;
            end else begin
               pkt.command = CMD_ARRIVAL;
               if (pick < 9) begin
                  pkt.arrival_time = $urandom;
               end else if (pick < 11) begin
                  pkt.arrival_time = 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
               end else begin
                  case ($urandom_range(0, 99)) inside
                     [0:49]:  later = {1'b0, now};
                     [50:84]: later = {1'b0, now} + 33'($urandom_range(0, 15));
                     [85:96]: later = {1'b0, now} + 33'($urandom_range(0, 200));
                     default: later = {1'b0, now} + 33'($urandom_range(0, 70000));
                  endcase
                  pkt.arrival_time = later[32] ? CLOCK_MAX : later[31:0];
               end
               now = pkt.arrival_time;
            end
            offer_item(pkt);
            got = predict_service(pkt);
         end
      end

      wait_drained();
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
